// File: rtl/core/assert_macros.svh
// Assertion macros for the history ring buffer RTL.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define OHRB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition must never be seen at a clock edge outside reset.
`define OHRB_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// File: rtl/core/ohrb_pkg.sv
// Shared types and constants of the overwrite-oldest history ring buffer.
// No dependencies; used by all modules in rtl/core.
package ohrb_pkg;

  // Storage geometry
  localparam int unsigned DEPTH  = 16;
  localparam int unsigned ELEM_W = 32;
  localparam int unsigned IDX_W  = $clog2(DEPTH);
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);

  localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(DEPTH);

  // Operation codes
  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_READ = 1'b1;

  // Status codes
  localparam logic STS_OK      = 1'b0;
  localparam logic STS_BAD_IDX = 1'b1;

  // Input beat
  typedef struct packed {
    logic              cmd;
    logic [ELEM_W-1:0] write_data;
    logic [IDX_W-1:0]  read_index;
  } in_beat_t;

  // Output beat
  typedef struct packed {
    logic [ELEM_W-1:0] read_data;
    logic              status;
    logic [CNT_W-1:0]  stored_count;
  } out_beat_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic push;
    logic read;
  } dp_cmd_t;

endpackage

// File: rtl/core/ohrb_ctrl.sv
// Controller of the history ring buffer: beat handshake and result slot.
// Depends on ohrb_pkg.
module ohrb_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_cmd_i,
  output logic             in_stall_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output ohrb_pkg::dp_cmd_t dp_cmd_o
);

  typedef enum logic {
    ST_EMPTY,
    ST_HOLD
  } state_e;

  state_e state_q;
  logic   accept;

  // A new beat enters when the result slot is free or drains this cycle
  assign in_stall_o  = (state_q == ST_HOLD) && out_stall_i;
  assign accept      = in_valid_i && !in_stall_o;
  assign out_valid_o = (state_q == ST_HOLD);

  // Datapath commands
  assign dp_cmd_o.load = accept;
  assign dp_cmd_o.push = accept && (in_cmd_i == ohrb_pkg::CMD_PUSH);
  assign dp_cmd_o.read = accept && (in_cmd_i == ohrb_pkg::CMD_READ);

  // Result slot state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_EMPTY;
    end else begin
      unique case (state_q)
        ST_EMPTY: begin
          if (accept) state_q <= ST_HOLD;
        end
        ST_HOLD: begin
          if (!accept && !out_stall_i) state_q <= ST_EMPTY;
        end
        default: state_q <= ST_EMPTY;
      endcase
    end
  end

endmodule

// File: rtl/core/ohrb_dp.sv
// Datapath of the history ring buffer: pointers, slot memory, result register.
// Depends on ohrb_pkg.
module ohrb_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ohrb_pkg::CNT_W-1:0]    cfg_wdata_i,
  input  ohrb_pkg::dp_cmd_t             dp_cmd_i,
  input  ohrb_pkg::in_beat_t            in_beat_i,
  output ohrb_pkg::out_beat_t           out_beat_o
);

  localparam int unsigned CW = ohrb_pkg::CNT_W;
  localparam int unsigned IW = ohrb_pkg::IDX_W;
  localparam int unsigned EW = ohrb_pkg::ELEM_W;

  logic [CW-1:0] cap_q;
  logic [IW-1:0] oldest_q, oldest_d;
  logic [CW-1:0] count_q, count_d;
  logic [EW-1:0] mem_q [ohrb_pkg::DEPTH];

  logic [EW-1:0] res_data_q;
  logic          res_sts_q;
  logic [CW-1:0] res_cnt_q;

  logic [CW-1:0] cap_eff;
  logic [IW-1:0] oldest_n;
  logic [CW-1:0] count_n;
  logic          full;
  logic          bad_idx;
  logic [CW-1:0] pos_sum;
  logic [IW-1:0] pos;

  // (a + b) mod cap, both operands below cap
  function automatic logic [CW-1:0] wrap_add(input logic [CW-1:0] a,
                                             input logic [CW-1:0] b,
                                             input logic [CW-1:0] cap);
    logic [CW-1:0] s;
    s = a + b;
    if (s >= cap) s = s - cap;
    return s;
  endfunction

  // Clamp capacity register to 1..DEPTH
  always_comb begin
    priority if (cap_q == '0) begin
      cap_eff = CW'(1);
    end else if (cap_q > CW'(ohrb_pkg::DEPTH)) begin
      cap_eff = CW'(ohrb_pkg::DEPTH);
    end else begin
      cap_eff = cap_q;
    end
  end

  // Keep pointers inside the active capacity
  assign oldest_n = ({1'b0, oldest_q} >= cap_eff) ? '0 : oldest_q;
  assign count_n  = (count_q > cap_eff) ? cap_eff : count_q;
  assign full     = (count_n == cap_eff);
  assign bad_idx  = ({1'b0, in_beat_i.read_index} >= count_n);

  // Slot address and pointer update
  always_comb begin
    oldest_d = oldest_n;
    count_d  = count_n;
    if (in_beat_i.cmd == ohrb_pkg::CMD_PUSH) begin
      if (full) begin
        pos_sum  = {1'b0, oldest_n};
        oldest_d = IW'(wrap_add({1'b0, oldest_n}, CW'(1), cap_eff));
      end else begin
        pos_sum = wrap_add({1'b0, oldest_n}, count_n, cap_eff);
        count_d = count_n + CW'(1);
      end
    end else begin
      pos_sum = wrap_add({1'b0, oldest_n}, {1'b0, in_beat_i.read_index}, cap_eff);
    end
  end
  assign pos = pos_sum[IW-1:0];

  // Pointer registers and capacity
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q    <= ohrb_pkg::CAP_RESET;
      oldest_q <= '0;
      count_q  <= '0;
    end else if (cfg_we_i) begin
      cap_q    <= cfg_wdata_i;
      oldest_q <= '0;
      count_q  <= '0;
    end else if (dp_cmd_i.load) begin
      oldest_q <= oldest_d;
      count_q  <= count_d;
    end
  end

  // Slot memory write
  always_ff @(posedge clk_i) begin
    if (dp_cmd_i.push) mem_q[pos] <= in_beat_i.write_data;
  end

  // Result register, read data straight from the memory
  always_ff @(posedge clk_i) begin
    if (dp_cmd_i.load) begin
      res_cnt_q  <= count_d;
      res_sts_q  <= (dp_cmd_i.read && bad_idx) ? ohrb_pkg::STS_BAD_IDX : ohrb_pkg::STS_OK;
      res_data_q <= (dp_cmd_i.read && !bad_idx) ? mem_q[pos] : '0;
    end
  end

  assign out_beat_o.read_data    = res_data_q;
  assign out_beat_o.status       = res_sts_q;
  assign out_beat_o.stored_count = res_cnt_q;

endmodule

// File: rtl/core/overwrite_history_ring_buffer.sv
// Overwrite-oldest history ring buffer, top level.
// Depends on ohrb_pkg, ohrb_ctrl, ohrb_dp and assert_macros.svh.
//
// Input channel: in_valid_i / in_stall_o carry one beat of in_beat_t, a push
// (cmd 0, write_data) or a read (cmd 1, read_index counted from the oldest).
// Output channel: out_valid_o / out_stall_i carry one out_beat_t per input
// beat, in order: read data (zero on push or bad index), status and the count
// held after the operation.
// The result is valid in the cycle after the input beat is taken.
// Throughput: one beat per cycle; the slot memory is written or read at the
// accept edge and its read port feeds the result register directly.
// While a result waits under out_stall_i, in_stall_o is high and no new beat
// is taken; once the result drains a new beat is taken in the same cycle.
// Reset empties the buffer and sets capacity to 16. A write on cfg_we_i sets
// the capacity (0 acts as 1, above 16 acts as 16) and empties the buffer;
// write it only while idle. Slots read only where written, no clearing pass.
`include "assert_macros.svh"

module overwrite_history_ring_buffer (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [ohrb_pkg::CNT_W-1:0] cfg_wdata_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  ohrb_pkg::in_beat_t         in_beat_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output ohrb_pkg::out_beat_t        out_beat_o
);

  ohrb_pkg::dp_cmd_t dp_cmd;

  // Handshake and result slot control
  ohrb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_cmd_i    (in_beat_i.cmd),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .dp_cmd_o    (dp_cmd)
  );

  // Pointers, storage and result
  ohrb_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .dp_cmd_i    (dp_cmd),
    .in_beat_i   (in_beat_i),
    .out_beat_o  (out_beat_o)
  );

  // Check terms
  logic in_take;
  logic cnt_ok;
  logic err_data;

  assign in_take  = in_valid_i && !in_stall_o;
  assign cnt_ok   = (out_beat_o.stored_count <= ohrb_pkg::CNT_W'(ohrb_pkg::DEPTH));
  assign err_data = (out_beat_o.status == ohrb_pkg::STS_BAD_IDX) &&
                    (out_beat_o.read_data != '0);

  // Checks
  `OHRB_ASSERT(a_accept_gives_result, in_take |=> out_valid_o, "accepted beat gave no result")
  `OHRB_ASSERT(a_count_bound, out_valid_o |-> cnt_ok, "stored count above depth")
  `OHRB_NEVER(a_err_data_zero, out_valid_o && err_data, "bad index result carries data")

endmodule
